[src/skpc_pkg.sv]
// skpc_pkg: shared types and codes for the size keyed preview cache
// holds request and response structs, the table entry type and scan result type
// no dependencies
`default_nettype none

package skpc_pkg;

    localparam int DIM_BITS    = 12;
    localparam int HANDLE_BITS = 16;
    localparam int AREA_BITS   = 2 * DIM_BITS;

    // request kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_INVAL = 2'd2;

    // response status codes
    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_SCALED = 2'd1;
    localparam logic [1:0] ST_MISS   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    typedef struct packed {
        logic [1:0]             kind;
        logic [DIM_BITS-1:0]    width;
        logic [DIM_BITS-1:0]    height;
        logic [HANDLE_BITS-1:0] handle;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic [HANDLE_BITS-1:0] source_handle;
        logic [DIM_BITS-1:0]    source_width;
        logic [DIM_BITS-1:0]    source_height;
        logic                   evicted_valid;
        logic [HANDLE_BITS-1:0] evicted_handle;
    } t_rsp;

    typedef struct packed {
        logic [DIM_BITS-1:0]    w;
        logic [DIM_BITS-1:0]    h;
        logic [HANDLE_BITS-1:0] hd;
    } t_entry;

    // what one pass over the table found
    typedef struct packed {
        logic                   ex_found;
        t_entry                 ex;
        logic                   pk_found;
        t_entry                 pk;
        logic                   f1_found;
        logic                   f2_found;
        logic [HANDLE_BITS-1:0] mn_hd;
    } t_scan_res;

endpackage

`default_nettype wire

[src/size_keyed_preview_cache.sv]
// size_keyed_preview_cache: ordered table of preview entries keyed by size
// one request at a time, scanned and shifted through the entry memory's one read and one write
// port; each request scans the held entries, drains and plans, an add then shifts entries and
// writes the new one, and the result is posted; a result still stalled delays the post, and the
// next request can be taken while the posted result is on the output
// synchronous active-low reset empties the table; entry contents are not cleared; skpc_pkg, skpc_scan
`default_nettype none

module size_keyed_preview_cache
    import skpc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 5
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_rsp      o_out_data
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DRN1 = 3'd2;
    localparam logic [2:0] S_DRN2 = 3'd3;
    localparam logic [2:0] S_PLAN = 3'd4;
    localparam logic [2:0] S_MOVE = 3'd5;
    localparam logic [2:0] S_PUT  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    t_entry r_mem [CACHE_ENTRIES];
    t_entry r_rdata;

    logic [2:0]       r_state;
    t_req             r_req;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_ptr, r_rd_idx, r_mv_dst, r_dst, r_last, r_pos;
    logic             r_rd_vld, r_mv_pend, r_up, r_evict;
    t_rsp             r_rsp, r_out;
    logic             r_out_valid;

    logic             accept, out_free;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             wr_en;
    t_entry           wr_data, new_ent;

    t_scan_res        scan;
    logic [IDX_W-1:0] f1_idx, f2_idx, mn_idx;

    logic             do_add, evict, j_found;
    logic [IDX_W-1:0] n_e, n_pos, j_idx;
    t_rsp             n_rsp;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_state != S_IDLE;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign new_ent    = '{w: r_req.width, h: r_req.height, hd: r_req.handle};

    skpc_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (accept),
        .i_vld    (r_rd_vld),
        .i_idx    (r_rd_idx),
        .i_ent    (r_rdata),
        .i_req_w  (r_req.width),
        .i_req_h  (r_req.height),
        .o_res    (scan),
        .o_f1_idx (f1_idx),
        .o_f2_idx (f2_idx),
        .o_mn_idx (mn_idx)
    );

    // entry memory: one read and one write port, registered read
    always_comb begin
        if (r_state == S_MOVE) begin
            rd_addr = r_up ? r_dst + IDX_W'(1) : r_dst - IDX_W'(1);
        end else begin
            rd_addr = r_ptr;
        end
        wr_en   = r_mv_pend || (r_state == S_PUT);
        wr_addr = r_mv_pend ? r_mv_dst : r_pos;
        wr_data = r_mv_pend ? r_rdata : new_ent;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rdata <= r_mem[rd_addr];
    end

    // plan the response and, for an add, the evict and insert geometry
    always_comb begin
        n_rsp  = '0;
        n_rsp.status = ST_DONE;
        do_add = 1'b0;
        case (r_req.kind)
            KIND_ADD: do_add = 1'b1;
            KIND_GET: begin
                if (scan.ex_found) begin
                    n_rsp.status        = ST_HIT;
                    n_rsp.source_handle = scan.ex.hd;
                    n_rsp.source_width  = scan.ex.w;
                    n_rsp.source_height = scan.ex.h;
                end else if (scan.pk_found) begin
                    n_rsp.status        = ST_SCALED;
                    n_rsp.source_handle = scan.pk.hd;
                    n_rsp.source_width  = scan.pk.w;
                    n_rsp.source_height = scan.pk.h;
                    do_add              = 1'b1;
                end else begin
                    n_rsp.status = ST_MISS;
                end
            end
            default: ;
        endcase

        evict = r_count == CNT_W'(CACHE_ENTRIES);
        if (do_add && evict) begin
            n_rsp.evicted_valid  = 1'b1;
            n_rsp.evicted_handle = scan.mn_hd;
        end

        // insertion slot, when full counted in the table after the smallest entry is gone
        if (scan.f1_found && f1_idx != mn_idx) begin
            j_found = 1'b1;
            j_idx   = f1_idx;
        end else begin
            j_found = scan.f2_found;
            j_idx   = f2_idx;
        end
        if (evict) begin
            n_e = mn_idx;
            if (!j_found) begin
                n_pos = IDX_W'(CACHE_ENTRIES - 1);
            end else if (j_idx < mn_idx) begin
                n_pos = j_idx;
            end else begin
                n_pos = j_idx - IDX_W'(1);
            end
        end else begin
            n_e   = r_count[IDX_W-1:0];
            n_pos = scan.f1_found ? f1_idx : r_count[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_mv_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld  <= r_state == S_SCAN;
            r_mv_pend <= r_state == S_MOVE;
            // in S_OUT a taken result is replaced by the new one below
            if (r_out_valid && !i_out_stall && r_state != S_OUT) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= (r_count == '0) ? S_DRN1 : S_SCAN;
                end
                S_SCAN: begin
                    if (CNT_W'(r_ptr) == r_count - CNT_W'(1)) r_state <= S_DRN1;
                end
                S_DRN1: r_state <= S_DRN2;
                S_DRN2: r_state <= S_PLAN;
                S_PLAN: begin
                    if (r_req.kind == KIND_INVAL) r_count <= '0;
                    if (!do_add) begin
                        r_state <= S_OUT;
                    end else if (n_pos == n_e) begin
                        r_state <= S_PUT;
                    end else begin
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    if (r_dst == r_last) r_state <= S_PUT;
                end
                S_PUT: begin
                    // last shifted entry lands first, then the new one
                    if (!r_mv_pend) begin
                        if (!r_evict) r_count <= r_count + CNT_W'(1);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // payload and index registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_data;
            r_ptr <= '0;
        end
        if (r_state == S_SCAN) begin
            r_rd_idx <= r_ptr;
            r_ptr    <= r_ptr + IDX_W'(1);
        end
        if (r_state == S_PLAN) begin
            r_rsp   <= n_rsp;
            r_pos   <= n_pos;
            r_evict <= evict;
            r_dst   <= n_e;
            r_up    <= n_pos > n_e;
            r_last  <= (n_pos > n_e) ? n_pos - IDX_W'(1) : n_pos + IDX_W'(1);
        end
        if (r_state == S_MOVE) begin
            r_mv_dst <= r_dst;
            r_dst    <= r_up ? r_dst + IDX_W'(1) : r_dst - IDX_W'(1);
        end
        if (r_state == S_OUT && out_free) r_out <= r_rsp;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[src/skpc_scan.sv]
// skpc_scan: evaluates table entries streamed out of the entry memory
// tracks exact match, usable larger pick, insertion candidates and smallest area
// depends on skpc_pkg
`default_nettype none

module skpc_scan
    import skpc_pkg::*;
#(
    parameter int IDX_W = 3
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_clear,
    input  wire logic                i_vld,
    input  wire logic [IDX_W-1:0]    i_idx,
    input  wire t_entry              i_ent,
    input  wire logic [DIM_BITS-1:0] i_req_w,
    input  wire logic [DIM_BITS-1:0] i_req_h,
    output t_scan_res                o_res,
    output logic [IDX_W-1:0]         o_f1_idx,
    output logic [IDX_W-1:0]         o_f2_idx,
    output logic [IDX_W-1:0]         o_mn_idx
);

    logic                   r_ex_found, r_pk_found, r_f1_found, r_f2_found, r_mn_found;
    logic                   r_ar_vld;
    t_entry                 r_ex, r_pk;
    logic [IDX_W-1:0]       r_f1, r_f2, r_mn_idx, r_ar_idx;
    logic [AREA_BITS-1:0]   r_ar, r_mn_area;
    logic [HANDLE_BITS-1:0] r_ar_hd, r_mn_hd;

    logic take_ex, take_pk, ins, take_f1, take_f2, take_mn;

    always_comb begin
        take_ex = i_vld && !r_ex_found && i_ent.w == i_req_w && i_ent.h == i_req_h;
        // current pick survives only if strictly larger in both dimensions
        take_pk = i_vld && i_ent.w >= i_req_w && i_ent.h >= i_req_h
                  && !(r_pk_found && r_pk.w > i_ent.w && r_pk.h > i_ent.h);
        ins     = i_vld && i_req_w > i_ent.w && i_req_h > i_ent.h;
        take_f1 = ins && !r_f1_found;
        take_f2 = ins && r_f1_found && !r_f2_found;
        take_mn = r_ar_vld && (!r_mn_found || r_ar < r_mn_area);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_ex_found <= 1'b0;
            r_pk_found <= 1'b0;
            r_f1_found <= 1'b0;
            r_f2_found <= 1'b0;
            r_mn_found <= 1'b0;
            r_ar_vld   <= 1'b0;
        end else begin
            r_ar_vld <= i_vld;
            if (take_ex) r_ex_found <= 1'b1;
            if (take_pk) r_pk_found <= 1'b1;
            if (take_f1) r_f1_found <= 1'b1;
            if (take_f2) r_f2_found <= 1'b1;
            if (take_mn) r_mn_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_ex) r_ex <= i_ent;
        if (take_pk) r_pk <= i_ent;
        if (take_f1) r_f1 <= i_idx;
        if (take_f2) r_f2 <= i_idx;
        r_ar     <= AREA_BITS'(i_ent.w) * AREA_BITS'(i_ent.h);
        r_ar_idx <= i_idx;
        r_ar_hd  <= i_ent.hd;
        if (take_mn) begin
            r_mn_area <= r_ar;
            r_mn_idx  <= r_ar_idx;
            r_mn_hd   <= r_ar_hd;
        end
    end

    always_comb begin
        o_res.ex_found = r_ex_found;
        o_res.ex       = r_ex;
        o_res.pk_found = r_pk_found;
        o_res.pk       = r_pk;
        o_res.f1_found = r_f1_found;
        o_res.f2_found = r_f2_found;
        o_res.mn_hd    = r_mn_hd;
    end

    assign o_f1_idx = r_f1;
    assign o_f2_idx = r_f2;
    assign o_mn_idx = r_mn_idx;

endmodule

`default_nettype wire

[verif/tb_size_keyed_preview_cache.sv]
// tb_size_keyed_preview_cache: self-checking bench for the size keyed preview cache
// predicts every response of the entry table in a scoreboard class, drives requests with tasks
// depends on skpc_pkg and size_keyed_preview_cache
`default_nettype none

module tb_size_keyed_preview_cache;
    import skpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CACHE_ENTRIES = 5;
    localparam int RANDOM_ITEMS  = 1275;
    // the one kind value that the block ignores
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    t_req req_data;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    t_rsp rsp_data;
    bit   calm;

    class preview_scoreboard #(int DEPTH = 5);
        t_entry slots[DEPTH];
        int     held;
        t_rsp   expected_q[$];
        int     n_errors;
        int     n_checked;
        int     n_hits;
        int     n_scaled;
        int     n_misses;
        int     n_evictions;

        function new();
            held        = 0;
            n_errors    = 0;
            n_checked   = 0;
            n_hits      = 0;
            n_scaled    = 0;
            n_misses    = 0;
            n_evictions = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [AREA_BITS-1:0] area_of(t_entry e);
            logic [AREA_BITS-1:0] w;
            logic [AREA_BITS-1:0] h;
            w = AREA_BITS'(e.w);
            h = AREA_BITS'(e.h);
            return w * h;
        endfunction

        // evict the smallest area (earliest on a tie) when full, then place the new entry
        function void insert_entry(input t_entry e, output logic ev_valid,
                                   output logic [HANDLE_BITS-1:0] ev_handle);
            int victim;
            int pos;
            int i;
            ev_valid  = 1'b0;
            ev_handle = '0;
            if (held >= DEPTH) begin
                victim = 0;
                for (i = 1; i < held; i++)
                    if (area_of(slots[victim]) > area_of(slots[i])) victim = i;
                ev_valid  = 1'b1;
                ev_handle = slots[victim].hd;
                for (i = victim; i + 1 < held; i++) slots[i] = slots[i + 1];
                held--;
            end
            pos = held;
            for (i = 0; i < held; i++) begin
                if (e.w > slots[i].w && e.h > slots[i].h) begin
                    pos = i;
                    break;
                end
            end
            for (i = held; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = e;
            held++;
        endfunction

        function void note_request(t_req r);
            t_rsp   rsp;
            t_entry fresh;
            logic   found;
            int     pick;
            int     i;
            rsp          = '0;
            rsp.status   = ST_DONE;
            fresh.w      = r.width;
            fresh.h      = r.height;
            fresh.hd     = r.handle;
            found        = 1'b0;
            pick         = 0;
            case (r.kind)
                KIND_ADD: begin
                    insert_entry(fresh, rsp.evicted_valid, rsp.evicted_handle);
                end
                KIND_GET: begin
                    for (i = 0; i < held; i++) begin
                        if (slots[i].w == r.width && slots[i].h == r.height) begin
                            found = 1'b1;
                            pick  = i;
                            break;
                        end
                    end
                    if (found) begin
                        rsp.status = ST_HIT;
                    end else begin
                        // current pick survives only if strictly larger in both dimensions
                        for (i = 0; i < held; i++) begin
                            if (slots[i].w >= r.width && slots[i].h >= r.height) begin
                                if (!(found && slots[pick].w > slots[i].w &&
                                      slots[pick].h > slots[i].h)) begin
                                    found = 1'b1;
                                    pick  = i;
                                end
                            end
                        end
                        rsp.status = found ? ST_SCALED : ST_MISS;
                    end
                    if (found) begin
                        rsp.source_handle = slots[pick].hd;
                        rsp.source_width  = slots[pick].w;
                        rsp.source_height = slots[pick].h;
                        if (rsp.status == ST_SCALED)
                            insert_entry(fresh, rsp.evicted_valid, rsp.evicted_handle);
                    end
                end
                KIND_INVAL: begin
                    held = 0;
                end
                default: begin
                end
            endcase
            if (rsp.status == ST_HIT) n_hits++;
            if (rsp.status == ST_SCALED) n_scaled++;
            if (rsp.status == ST_MISS) n_misses++;
            if (rsp.evicted_valid) n_evictions++;
            expected_q.push_back(rsp);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            n_errors++;
            $display("mismatch at response %0d: %s got %0h expected %0h",
                     n_checked, what, got, want);
        endtask

        task check_response(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                report_mismatch("response with no request waiting, status",
                                32'(got.status), 32'd0);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.source_handle !== want.source_handle)
                report_mismatch("source_handle", 32'(got.source_handle),
                                32'(want.source_handle));
            if (got.source_width !== want.source_width)
                report_mismatch("source_width", 32'(got.source_width),
                                32'(want.source_width));
            if (got.source_height !== want.source_height)
                report_mismatch("source_height", 32'(got.source_height),
                                32'(want.source_height));
            if (got.evicted_valid !== want.evicted_valid)
                report_mismatch("evicted_valid", 32'(got.evicted_valid),
                                32'(want.evicted_valid));
            if (got.evicted_handle !== want.evicted_handle)
                report_mismatch("evicted_handle", 32'(got.evicted_handle),
                                32'(want.evicted_handle));
            n_checked++;
        endtask
    endclass

    preview_scoreboard #(CACHE_ENTRIES) sb;

    size_keyed_preview_cache #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (req_valid),
        .o_in_stall (req_stall),
        .i_in_data  (req_data),
        .o_out_valid(rsp_valid),
        .i_out_stall(rsp_stall),
        .o_out_data (rsp_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("tb_size_keyed_preview_cache failed");
        $finish;
    end

    // response side: check what is taken, then pick the stall for the next cycle
    always @(posedge clk) begin
        if (rst_n && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
        rsp_stall <= !calm && ($urandom_range(0, 99) < 26);
    end

    function automatic t_req make_req(logic [1:0] k, int w, int h,
                                      logic [HANDLE_BITS-1:0] hd);
        t_req r;
        r.kind   = k;
        r.width  = w[DIM_BITS-1:0];
        r.height = h[DIM_BITS-1:0];
        r.handle = hd;
        return r;
    endfunction

    // mostly tiny sizes so that hits, ties and usable larger entries are common
    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(0, 7);
        if (r < 90) return $urandom_range(0, 63);
        return $urandom_range(0, 4095);
    endfunction

    task automatic send_req(t_req r);
        if (!calm && $urandom_range(0, 99) < 26) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (req_stall);
        sb.note_request(r);
    endtask

    task automatic send_random_req();
        int   r;
        logic [1:0] k;
        r = $urandom_range(0, 99);
        if (r < 42) k = KIND_ADD;
        else if (r < 93) k = KIND_GET;
        else if (r < 97) k = KIND_INVAL;
        else k = KIND_SPARE;
        send_req(make_req(k, pick_dim(), pick_dim(), HANDLE_BITS'($urandom_range(0, 65535))));
    endtask

    initial begin
        int n_random;
        sb        = new();
        calm      = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(make_req(KIND_GET,   0,    0,    16'h0007));   // empty table
        send_req(make_req(KIND_ADD,   4095, 4095, 16'hFFFF));
        send_req(make_req(KIND_ADD,   0,    0,    16'h0000));
        send_req(make_req(KIND_ADD,   10,   10,   16'h0001));
        send_req(make_req(KIND_ADD,   10,   10,   16'h0002));
        send_req(make_req(KIND_ADD,   20,   5,    16'h0003));   // now full
        send_req(make_req(KIND_GET,   10,   10,   16'h1111));
        send_req(make_req(KIND_GET,   0,    0,    16'h2222));
        send_req(make_req(KIND_GET,   4095, 4095, 16'h3333));
        send_req(make_req(KIND_GET,   10,   5,    16'h0004));   // scaled, evicts zero area
        send_req(make_req(KIND_ADD,   4095, 0,    16'hAAAA));
        send_req(make_req(KIND_ADD,   11,   11,   16'h5555));
        send_req(make_req(KIND_ADD,   1,    1,    16'h0006));   // three-way area tie
        send_req(make_req(KIND_SPARE, 4095, 4095, 16'hFFFF));
        send_req(make_req(KIND_INVAL, 0,    0,    16'h0000));
        send_req(make_req(KIND_ADD,   50,   50,   16'h0031));
        send_req(make_req(KIND_ADD,   40,   40,   16'h0032));
        send_req(make_req(KIND_ADD,   30,   30,   16'h0033));
        send_req(make_req(KIND_ADD,   20,   20,   16'h0034));
        send_req(make_req(KIND_ADD,   1,    100,  16'h0030));
        // only usable entry is also the smallest, so the add evicts the reported source
        send_req(make_req(KIND_GET,   1,    60,   16'h0035));
        send_req(make_req(KIND_GET,   4095, 4095, 16'h0036));
        send_req(make_req(KIND_GET,   0,    0,    16'h0037));
        send_req(make_req(KIND_INVAL, 4095, 4095, 16'hFFFF));
        send_req(make_req(KIND_ADD,   0,    4095, 16'h8000));

        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            calm = (n_random >= 500 && n_random < 800);
            send_random_req();
            if (req_data.kind != KIND_SPARE) n_random++;
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (32) @(posedge clk);

        $display("checked %0d responses: %0d exact hits, %0d scaled from larger, %0d misses",
                 sb.n_checked, sb.n_hits, sb.n_scaled, sb.n_misses);
        $display("%0d evictions, %0d mismatches", sb.n_evictions, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("tb_size_keyed_preview_cache passed");
        end else begin
            $display("tb_size_keyed_preview_cache failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
src/skpc_pkg.sv
src/skpc_scan.sv
src/size_keyed_preview_cache.sv
verif/tb_size_keyed_preview_cache.sv
